FILE: rtl/core/sscr_pkg.sv
// shared types, constants and helper functions for the six-step commutator
`timescale 1ns / 1ps
`default_nettype none

package sscr_pkg;

   localparam int DATA_W    = 16;
   localparam int INDEX_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_STEPS = 6;
   localparam int PWM_BITS_DEFAULT = 16;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DUTY        = 3'd0,
      CSR_DUTY_MIN    = 3'd1,
      CSR_DUTY_MAX    = 3'd2,
      CSR_DELAY_MIN   = 3'd3,
      CSR_DELAY_MAX   = 3'd4,
      CSR_START_DELAY = 3'd5
   } csr_index_type;

   localparam logic [DATA_W-1:0] DUTY_RESET        = 16'd0;
   localparam logic [DATA_W-1:0] DUTY_MIN_RESET    = 16'd0;
   localparam logic [DATA_W-1:0] DUTY_MAX_RESET    = 16'hFFFF;
   localparam logic [DATA_W-1:0] DELAY_MIN_RESET   = 16'd1;
   localparam logic [DATA_W-1:0] DELAY_MAX_RESET   = 16'd100;
   localparam logic [DATA_W-1:0] START_DELAY_RESET = 16'd100;

   // phase bits: A, B, C from msb to lsb
   localparam logic [2:0] PHASE_A = 3'h4;
   localparam logic [2:0] PHASE_B = 3'h2;
   localparam logic [2:0] PHASE_C = 3'h1;
   localparam logic [2:0] PHASE_NONE = 3'h0;

   localparam logic [INDEX_W-1:0] LAST_STEP = INDEX_W'(NUM_STEPS - 1);

   typedef struct packed {
      logic [DATA_W-1:0] duty;
      logic [DATA_W-1:0] duty_min;
      logic [DATA_W-1:0] duty_max;
      logic [DATA_W-1:0] delay_min;
      logic [DATA_W-1:0] delay_max;
      logic [DATA_W-1:0] start_delay;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0]  compare_a;
      logic [DATA_W-1:0]  compare_b;
      logic [DATA_W-1:0]  compare_c;
      logic [INDEX_W-1:0] next_index;
      logic [DATA_W-1:0]  current_delay;
      logic               commutated;
   } rsp_type;

   // crossed limits: values below lo give lo, all others give hi
   function automatic logic [DATA_W-1:0] clamp_value(
      input logic [DATA_W-1:0] v,
      input logic [DATA_W-1:0] lo,
      input logic [DATA_W-1:0] hi
   );
      logic [DATA_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // six-step drive pattern, out-of-range index falls back to the first step
   function automatic logic [2:0] step_pattern(input logic [INDEX_W-1:0] idx);
      logic [2:0] p;
      case (idx)
         3'd1:    p = PHASE_A | PHASE_C;
         3'd2:    p = PHASE_A;
         3'd3:    p = PHASE_A | PHASE_B;
         3'd4:    p = PHASE_B;
         3'd5:    p = PHASE_B | PHASE_C;
         default: p = PHASE_C;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sscr_csr.sv
// configuration register file for the six-step commutator
`timescale 1ns / 1ps
`default_nettype none

module sscr_csr
   import sscr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_DUTY:        cfg_in.duty        = csr_wdata;
            CSR_DUTY_MIN:    cfg_in.duty_min    = csr_wdata;
            CSR_DUTY_MAX:    cfg_in.duty_max    = csr_wdata;
            CSR_DELAY_MIN:   cfg_in.delay_min   = csr_wdata;
            CSR_DELAY_MAX:   cfg_in.delay_max   = csr_wdata;
            CSR_START_DELAY: cfg_in.start_delay = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty        <= DUTY_RESET;
         cfg_ff.duty_min    <= DUTY_MIN_RESET;
         cfg_ff.duty_max    <= DUTY_MAX_RESET;
         cfg_ff.delay_min   <= DELAY_MIN_RESET;
         cfg_ff.delay_max   <= DELAY_MAX_RESET;
         cfg_ff.start_delay <= START_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sscr_step.sv
// commutation state and per-tick next-state / result logic
`timescale 1ns / 1ps
`default_nettype none

module sscr_step
   import sscr_pkg::*;
#(
   parameter int PWM_BITS = PWM_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    tick_fire,
   input  wire logic    tick_restart,
   output rsp_type      result
);

   // duty saturation from the pwm counter width
   localparam logic [DATA_W-1:0] DUTY_LIMIT =
      (PWM_BITS >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((32'd1 << PWM_BITS) - 32'd1);

   logic [INDEX_W-1:0] step_index_ff,   step_index_in;
   logic [2:0]         pattern_ff,      pattern_in;
   logic [DATA_W-1:0]  interval_ff,     interval_in;
   logic [DATA_W-1:0]  wait_left_ff,    wait_left_in;
   logic [DATA_W-1:0]  applied_duty_ff, applied_duty_in;
   logic               commutate;
   logic [DATA_W-1:0]  duty_clamped;

   always_comb begin
      duty_clamped = clamp_value(cfg.duty, cfg.duty_min, cfg.duty_max);
      if (duty_clamped > DUTY_LIMIT) begin
         duty_clamped = DUTY_LIMIT;
      end

      step_index_in   = step_index_ff;
      pattern_in      = pattern_ff;
      interval_in     = interval_ff;
      wait_left_in    = wait_left_ff;
      applied_duty_in = applied_duty_ff;
      commutate       = 1'b0;

      if (tick_restart) begin
         step_index_in   = '0;
         pattern_in      = PHASE_NONE;
         interval_in     = clamp_value(cfg.start_delay, cfg.delay_min, cfg.delay_max);
         wait_left_in    = '0;
         applied_duty_in = '0;
      end else if (wait_left_ff > DATA_W'(1)) begin
         wait_left_in = wait_left_ff - DATA_W'(1);
      end else begin
         commutate = 1'b1;
         // first commutation after restart keeps the start interval
         if (pattern_ff != PHASE_NONE && interval_ff > cfg.delay_min) begin
            interval_in = interval_ff - DATA_W'(1);
         end
         applied_duty_in = duty_clamped;
         pattern_in      = step_pattern(step_index_ff);
         step_index_in   = (step_index_ff >= LAST_STEP) ? '0
                                                        : step_index_ff + INDEX_W'(1);
         wait_left_in    = interval_in;
      end

      result.compare_a     = ((pattern_in & PHASE_A) != PHASE_NONE) ? applied_duty_in : '0;
      result.compare_b     = ((pattern_in & PHASE_B) != PHASE_NONE) ? applied_duty_in : '0;
      result.compare_c     = ((pattern_in & PHASE_C) != PHASE_NONE) ? applied_duty_in : '0;
      result.next_index    = step_index_in;
      result.current_delay = interval_in;
      result.commutated    = commutate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_index_ff   <= '0;
         pattern_ff      <= PHASE_NONE;
         interval_ff     <= clamp_value(START_DELAY_RESET, DELAY_MIN_RESET, DELAY_MAX_RESET);
         wait_left_ff    <= '0;
         applied_duty_ff <= '0;
      end else if (tick_fire) begin
         step_index_ff   <= step_index_in;
         pattern_ff      <= pattern_in;
         interval_ff     <= interval_in;
         wait_left_ff    <= wait_left_in;
         applied_duty_ff <= applied_duty_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/six_step_commutator_ramp_top.sv
// top level of the open-loop six-step commutator with start ramp
//
// usage:
//  - req channel: one word per timer tick, req_restart = 1 restarts the
//    pattern sequence and reloads the clamped start delay
//  - rsp channel: one word per tick with the three phase compares, the
//    pattern index for the next commutation, the interval in force and a
//    flag that is set when this tick applied a new pattern
//  - csr port: single-cycle writes of the six 16-bit registers, no read-back;
//    write only while no tick is in flight
//  - a req word passes the input register, then the result register;
//    throughput one word per cycle while the receiver keeps rsp_ready high,
//    set by the single state update between the two registers
//  - a stalled receiver holds the result register; one more tick can still
//    sit in the input register, after that req_ready drops
//  - reset clears the valid flags of both registers, the commutation state and
//    the csrs to their defaults; the first plain tick after reset commutates
`timescale 1ns / 1ps
`default_nettype none

module six_step_commutator_ramp_top
   import sscr_pkg::*;
#(
   parameter int PWM_BITS = PWM_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // tick input
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_restart,
   // result output
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [DATA_W-1:0]         rsp_compare_a,
   output logic [DATA_W-1:0]         rsp_compare_b,
   output logic [DATA_W-1:0]         rsp_compare_c,
   output logic [INDEX_W-1:0]        rsp_next_index,
   output logic [DATA_W-1:0]         rsp_current_delay,
   output logic                      rsp_commutated,
   // configuration writes
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata
);

   cfg_type cfg;
   rsp_type step_result;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_restart_ff;
   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_word_ff;

   logic advance;

   // tick moves into the result register when that slot is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   sscr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   sscr_step #(
      .PWM_BITS (PWM_BITS)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .tick_fire    (advance),
      .tick_restart (in_restart_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_restart_ff <= req_restart;
      end
      if (advance) begin
         out_word_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_compare_a     = out_word_ff.compare_a;
   assign rsp_compare_b     = out_word_ff.compare_b;
   assign rsp_compare_c     = out_word_ff.compare_c;
   assign rsp_next_index    = out_word_ff.next_index;
   assign rsp_current_delay = out_word_ff.current_delay;
   assign rsp_commutated    = out_word_ff.commutated;

   // a restart tick gives an idle, non-commutating word at index zero
   assert property (@(posedge clock) disable iff (reset)
      advance && in_restart_ff |=> rsp_valid && !rsp_commutated &&
         rsp_next_index == '0 && rsp_compare_a == '0 &&
         rsp_compare_b == '0 && rsp_compare_c == '0)
      else $error("restart tick did not clear the sequence");

   // a waiting tick in the input register is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_restart_ff))
      else $error("input register lost a pending tick");

   // every pattern leaves at least one phase idle, index stays in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_compare_a == '0 || rsp_compare_b == '0 ||
         rsp_compare_c == '0) && rsp_next_index <= LAST_STEP)
      else $error("bad phase pattern or step index");

endmodule

`default_nettype wire
